// ===== rtl/core/ipv4_destination_blocklist_assert.svh =====
// Assertion macros shared by the blocklist RTL.
`ifndef IPV4_DESTINATION_BLOCKLIST_ASSERT_SVH
`define IPV4_DESTINATION_BLOCKLIST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IDB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("blocklist assertion failed");

// Next-cycle implication, disabled during reset.
`define IDB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blocklist assertion failed");

`endif

// ===== rtl/core/ipv4_dbl_pkg.sv =====
`default_nettype none

package ipv4_dbl_pkg;

    localparam int ACTION_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_CHECK  = 2'd0;
    localparam action_t ACT_ADD    = 2'd1;
    localparam action_t ACT_REMOVE = 2'd2;

    localparam status_t STATUS_DONE      = 2'd0;
    localparam status_t STATUS_DUPLICATE = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } dbl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dbl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dbl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipv4_dbl_ram.sv =====
`default_nettype none

module ipv4_dbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_dbl_dp.sv =====
`default_nettype none
`include "ipv4_destination_blocklist_assert.svh"

module ipv4_dbl_dp #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ipv4_dbl_pkg::dbl_cmd_t cmd,
    output ipv4_dbl_pkg::dbl_sts_t     sts,
    input  wire ipv4_dbl_pkg::action_t in_action,
    input  wire logic [31:0]           in_address,
    output logic                       out_drop,
    output ipv4_dbl_pkg::status_t      out_status
);

    import ipv4_dbl_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;

    action_t                  op_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     hit_reg, hit_next;
    logic [IW-1:0]            hit_idx_reg, hit_idx_next;
    logic                     free_reg, free_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     drop_reg, drop_next;
    status_t                  status_reg, status_next;

    logic [CW-1:0]     cnt_dec;
    logic [IW-1:0]     cmp_idx;
    logic              cmp_en;
    logic [ADDR_W-1:0] ram_rdata;
    logic              wr_en;

    assign cnt_dec       = cnt_reg - CW'(1);
    assign cmp_idx       = cnt_dec[IW-1:0];
    assign cmp_en        = cmd.step && (cnt_reg != '0);
    assign sts.scan_last = (cnt_reg == CW'(TABLE_ENTRIES));
    assign wr_en         = cmd.commit && (op_reg == ACT_ADD) && !hit_reg && free_reg;

    ipv4_dbl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (free_idx_reg),
        .wdata (addr_reg),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        drop_next     = drop_reg;
        status_next   = status_reg;
        if (cmd.load) begin
            cnt_next  = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        if (cmd.step && !sts.scan_last) begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmp_en) begin
            // compare the entry read in the previous cycle
            if (valid_reg[cmp_idx] && (ram_rdata == addr_reg) && !hit_reg) begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx;
            end
            if (!valid_reg[cmp_idx] && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx;
            end
        end
        if (cmd.commit) begin
            drop_next   = 1'b0;
            status_next = STATUS_DONE;
            priority if (op_reg == ACT_CHECK) begin
                drop_next = hit_reg;
            end else if (op_reg == ACT_ADD) begin
                if (hit_reg) begin
                    status_next = STATUS_DUPLICATE;
                end else if (!free_reg) begin
                    status_next = STATUS_FULL;
                end else begin
                    valid_next[free_idx_reg] = 1'b1;
                end
            end else if (op_reg == ACT_REMOVE) begin
                if (hit_reg) begin
                    valid_next[hit_idx_reg] = 1'b0;
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end else begin
                drop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_action;
            addr_reg <= in_address;
        end
        cnt_reg      <= cnt_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        drop_reg     <= drop_next;
        status_reg   <= status_next;
    end

    assign out_drop   = drop_reg;
    assign out_status = status_reg;

    `IDB_ASSERT_NEXT(a_load_clears_scan, aclk, aresetn, cmd.load,
        (cnt_reg == '0) && !hit_reg && !free_reg)
    `IDB_ASSERT_NEXT(a_add_sets_valid, aclk, aresetn, wr_en, valid_reg[$past(free_idx_reg)])
    `IDB_ASSERT_NOW(a_hit_not_free, aclk, aresetn, hit_reg && free_reg,
        hit_idx_reg != free_idx_reg)

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_dbl_ctrl.sv =====
`default_nettype none
`include "ipv4_destination_blocklist_assert.svh"

module ipv4_dbl_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output ipv4_dbl_pkg::dbl_cmd_t      cmd,
    input  wire ipv4_dbl_pkg::dbl_sts_t sts
);

    import ipv4_dbl_pkg::*;

    dbl_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `IDB_ASSERT_NOW(a_commit_out_free, aclk, aresetn, cmd.commit, out_free)
    `IDB_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid_reg && !m_tready, m_tvalid_reg)
    `IDB_ASSERT_NEXT(a_scan_ends, aclk, aresetn, (state_reg == S_SCAN) && sts.scan_last,
        state_reg == S_FINISH)

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_destination_blocklist.sv =====
// IPv4 destination blocklist.
// Slave stream: one transfer per request, s_tdata holds the action (check,
// add, remove) and a 32-bit address. Master stream: one transfer per request,
// m_tdata holds the drop verdict and a status code (done, duplicate,
// not found, table full).
// Each request scans all TABLE_ENTRIES slots of the address RAM, one read
// per cycle, with the compare in the cycle after the read. The result shows on
// m_tvalid after the scan, once the output register is free. The next request
// is taken only after that result is committed, so requests do not overlap
// in the scan, which uses the single read port of the address RAM.
// Reset (aresetn low, synchronous) clears all valid marks at once, empties
// the output register and returns to idle; the address RAM is not cleared.
// A finished result waits in the output register while m_tready is low; the
// next request is still taken and scanned, and its result is held until the
// output register is free.
`default_nettype none

module ipv4_destination_blocklist #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [1:0] action, [33:2] address, [39:34] zero
    input  wire logic [ipv4_dbl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] drop, [2:1] status, [7:3] zero
    output logic      [ipv4_dbl_pkg::M_TDATA_W-1:0] m_tdata
);

    import ipv4_dbl_pkg::*;

    dbl_cmd_t cmd;
    dbl_sts_t sts;
    logic     out_drop;
    status_t  out_status;

    ipv4_dbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ipv4_dbl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (s_tdata[ACTION_W-1:0]),
        .in_address (s_tdata[ACTION_W+ADDR_W-1:ACTION_W]),
        .out_drop   (out_drop),
        .out_status (out_status)
    );

    assign m_tdata = {{(M_TDATA_W-STATUS_W-1){1'b0}}, out_status, out_drop};

endmodule

`default_nettype wire
